// ----- sv/atmr_pkg.sv -----
// Shared types and constants of the obstacle table move resolver.
`default_nettype none

package atmr_pkg;

  localparam int Q_W    = 24;          // signed Q16.8 coordinate width
  localparam int SZ_W   = 12;          // size width in whole pixels
  localparam int FRAC_W = 8;           // fraction bits of a coordinate
  localparam int EDGE_W = Q_W + 2;     // edge sums kept at full precision
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes (paddr[2])
  localparam logic REG_HITBOX_W = 1'b0;
  localparam logic REG_HITBOX_H = 1'b1;

  localparam logic [SZ_W-1:0] HITBOX_RST = 12'd16;

  // Request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SAT,
    ST_EDGE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic add_wr;
    logic sat;
    logic edge_ld;
    logic acc_clr;
    logic scan_clr;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
  } status_t;

  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic [SZ_W-1:0]       w;
    logic [SZ_W-1:0]       h;
  } obst_t;

endpackage

`default_nettype wire

// ----- sv/atmr_ctrl.sv -----
// Controller state machine: sequences adds, table scans and result hand-off.
`default_nettype none

module atmr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire atmr_pkg::status_t status,
  output atmr_pkg::cmd_t         cmd
);
  import atmr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = (req_type == REQ_MOVE) ? ST_SAT : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_wr = 1'b1;
        state_next = ST_FIN;
      end
      ST_SAT: begin
        cmd.sat     = 1'b1;
        cmd.acc_clr = 1'b1;
        state_next  = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.edge_ld  = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next   = status.cnt_zero ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/atmr_dp.sv -----
// Datapath: obstacle memory, fill count, overlap tests and result register.
`default_nettype none

module atmr_dp #(
  parameter int MAX_RECTS = 128,
  parameter int IDX_W     = 7,
  parameter int CNT_W     = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire atmr_pkg::cmd_t                    cmd,
  output atmr_pkg::status_t                      status,
  input  wire logic [atmr_pkg::SZ_W-1:0]         mover_w,
  input  wire logic [atmr_pkg::SZ_W-1:0]         mover_h,
  input  wire logic                              req_type,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   rect_x,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   rect_y,
  input  wire logic [atmr_pkg::SZ_W-1:0]         rect_w,
  input  wire logic [atmr_pkg::SZ_W-1:0]         rect_h,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   pos_x,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   pos_y,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   step_x,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   step_y,
  output logic signed [atmr_pkg::Q_W-1:0]        new_x,
  output logic signed [atmr_pkg::Q_W-1:0]        new_y,
  output logic                                   blocked_x,
  output logic                                   blocked_y,
  output logic                                   table_full
);
  import atmr_pkg::*;

  localparam int PAD_W = EDGE_W - SZ_W - FRAC_W;
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  obst_t mem [MAX_RECTS];
  obst_t rd_data;
  logic  rd_vld;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_idx;
  logic             tbl_full;

  // Latched request
  logic                  req;
  obst_t                 rect;
  logic signed [Q_W-1:0] px, py, sx, sy;

  // Candidate positions and box far edges
  logic signed [Q_W-1:0]    cx, cy;
  logic signed [EDGE_W-1:0] cx_e, px_e, py_e, cy_e;

  logic hit_x, hit_ycx, hit_ypx, was_full;

  logic signed [Q_W:0] sum_x, sum_y;
  logic signed [EDGE_W-1:0] bw, bh;
  logic signed [EDGE_W-1:0] ox_lo, ox_hi, oy_lo, oy_hi;
  logic ov_cx, ov_px, ov_py, ov_cy;
  logic sel_hit_y;

  assign tbl_full = (count == CNT_W'(MAX_RECTS));
  assign status.cnt_zero  = (count == '0);
  assign status.scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req    <= req_type;
      rect.x <= rect_x;
      rect.y <= rect_y;
      rect.w <= rect_w;
      rect.h <= rect_h;
      px     <= pos_x;
      py     <= pos_y;
      sx     <= step_x;
      sy     <= step_y;
    end
  end

  // Saturating step on both axes
  assign sum_x = {px[Q_W-1], px} + {sx[Q_W-1], sx};
  assign sum_y = {py[Q_W-1], py} + {sy[Q_W-1], sy};

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      if (sum_x[Q_W] != sum_x[Q_W-1]) begin
        cx <= sum_x[Q_W] ? Q_MIN : Q_MAX;
      end else begin
        cx <= sum_x[Q_W-1:0];
      end
      if (sum_y[Q_W] != sum_y[Q_W-1]) begin
        cy <= sum_y[Q_W] ? Q_MIN : Q_MAX;
      end else begin
        cy <= sum_y[Q_W-1:0];
      end
    end
  end

  assign bw = signed'({{PAD_W{1'b0}}, mover_w, {FRAC_W{1'b0}}});
  assign bh = signed'({{PAD_W{1'b0}}, mover_h, {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (cmd.edge_ld) begin
      cx_e <= EDGE_W'(cx) + bw;
      px_e <= EDGE_W'(px) + bw;
      py_e <= EDGE_W'(py) + bh;
      cy_e <= EDGE_W'(cy) + bh;
    end
  end

  // Fill count and memory write
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.add_wr && !tbl_full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr && !tbl_full) begin
      mem[count[IDX_W-1:0]] <= rect;
    end
    if (cmd.add_wr) begin
      was_full <= tbl_full;
    end
  end

  // Scan: one registered read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_issue;
      if (cmd.scan_clr) begin
        scan_idx <= '0;
      end else if (cmd.rd_issue) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[scan_idx];
    end
  end

  assign ox_lo = EDGE_W'(rd_data.x);
  assign oy_lo = EDGE_W'(rd_data.y);
  assign ox_hi = ox_lo + signed'({{PAD_W{1'b0}}, rd_data.w, {FRAC_W{1'b0}}});
  assign oy_hi = oy_lo + signed'({{PAD_W{1'b0}}, rd_data.h, {FRAC_W{1'b0}}});

  // Strict overlap of the box span with the obstacle span on each axis
  assign ov_cx = (EDGE_W'(cx) < ox_hi) && (cx_e > ox_lo);
  assign ov_px = (EDGE_W'(px) < ox_hi) && (px_e > ox_lo);
  assign ov_py = (EDGE_W'(py) < oy_hi) && (py_e > oy_lo);
  assign ov_cy = (EDGE_W'(cy) < oy_hi) && (cy_e > oy_lo);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      hit_x   <= 1'b0;
      hit_ycx <= 1'b0;
      hit_ypx <= 1'b0;
    end else if (rd_vld) begin
      hit_x   <= hit_x   | (ov_cx & ov_py);
      hit_ycx <= hit_ycx | (ov_cx & ov_cy);
      hit_ypx <= hit_ypx | (ov_px & ov_cy);
    end
  end

  assign sel_hit_y = hit_x ? hit_ypx : hit_ycx;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (req == REQ_MOVE) begin
        new_x      <= hit_x ? px : cx;
        new_y      <= sel_hit_y ? py : cy;
        blocked_x  <= hit_x;
        blocked_y  <= sel_hit_y;
        table_full <= 1'b0;
      end else begin
        new_x      <= '0;
        new_y      <= '0;
        blocked_x  <= 1'b0;
        blocked_y  <= 1'b0;
        table_full <= was_full;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/aabb_table_move_resolver_core.sv -----
// Top level of the obstacle table move resolver: register port, controller, datapath.
// Add request: ADD, then FIN, where the result is registered; then back to IDLE.
// Move request: SAT, EDGE, SCAN over the stored rectangles, DRAIN and FIN; with an
// empty table EDGE goes straight to FIN. A new request is taken only back in IDLE.
// The scan reads the single-port obstacle memory once per entry, one entry per cycle.
// Synchronous active-high reset empties the table and sets both hitbox sizes to 16.
`default_nettype none

module aabb_table_move_resolver_core #(
  parameter int MAX_RECTS = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [atmr_pkg::APB_AW-1:0]       paddr,
  input  wire logic [atmr_pkg::APB_DW-1:0]       pwdata,
  output logic [atmr_pkg::APB_DW-1:0]            prdata,
  output logic                                   pready,
  // Request channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              req_type,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   rect_x,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   rect_y,
  input  wire logic [atmr_pkg::SZ_W-1:0]         rect_w,
  input  wire logic [atmr_pkg::SZ_W-1:0]         rect_h,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   pos_x,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   pos_y,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   step_x,
  input  wire logic signed [atmr_pkg::Q_W-1:0]   step_y,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [atmr_pkg::Q_W-1:0]        new_x,
  output logic signed [atmr_pkg::Q_W-1:0]        new_y,
  output logic                                   blocked_x,
  output logic                                   blocked_y,
  output logic                                   table_full
);
  import atmr_pkg::*;

  // Table index and fill count widths; the count must be able to hold MAX_RECTS itself.
  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  logic [SZ_W-1:0] mover_w;
  logic [SZ_W-1:0] mover_h;
  logic            cfg_wr;
  logic            cfg_idx;

  cmd_t    cmd;
  status_t status;

  // The port never stalls. Register index is the word address; byte offset bits are ignored.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mover_w <= HITBOX_RST;
      mover_h <= HITBOX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HITBOX_W: mover_w <= pwdata[SZ_W-1:0];
        REG_HITBOX_H: mover_h <= pwdata[SZ_W-1:0];
        default:      mover_w <= mover_w;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HITBOX_W: prdata = {{(APB_DW-SZ_W){1'b0}}, mover_w};
      REG_HITBOX_H: prdata = {{(APB_DW-SZ_W){1'b0}}, mover_h};
      default:      prdata = '0;
    endcase
  end

  // The controller accepts a request only when idle, but a finished result may still be
  // waiting in the output register, so a new request overlaps the hand-off of the last.
  atmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath scans the table once per move. For each entry it tests the box at the
  // stepped x with the old y, and the stepped y at both candidate x positions, so the
  // final y answer is picked once the x outcome is known.
  atmr_dp #(
    .MAX_RECTS (MAX_RECTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mover_w    (mover_w),
    .mover_h    (mover_h),
    .req_type   (req_type),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_w     (rect_w),
    .rect_h     (rect_h),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .step_x     (step_x),
    .step_y     (step_y),
    .new_x      (new_x),
    .new_y      (new_y),
    .blocked_x  (blocked_x),
    .blocked_y  (blocked_y),
    .table_full (table_full)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the obstacle table move resolver core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atmr_pkg::*;

  // The table depth matches the default of the block, so the table really fills up.
  localparam int     MAX_RECTS        = 128;
  // One whole pixel in Q16.8.
  localparam int     PX               = 256;
  localparam longint Q_HI             = (longint'(1) << (Q_W - 1)) - 1;
  localparam longint Q_LO             = -(longint'(1) << (Q_W - 1));
  localparam int     PHASES           = 6;
  localparam int     RANDOM_PER_PHASE = 190;
  // Long receiver stall; far beyond one move over a full table.
  localparam int     LONG_HOLD        = 400;
  // Quiet cycles after the last result; covers the slowest move.
  localparam int     DRAIN_CYCLES     = MAX_RECTS + 16;
  // Cycles with no accepted request, result or register access before giving up.
  localparam int     WATCHDOG_LIMIT   = 4000;
  localparam int     MAX_PRINTS       = 40;

  // One request as the sender presents it.
  typedef struct packed {
    logic                  req_type;
    logic signed [Q_W-1:0] rect_x;
    logic signed [Q_W-1:0] rect_y;
    logic [SZ_W-1:0]       rect_w;
    logic [SZ_W-1:0]       rect_h;
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] step_x;
    logic signed [Q_W-1:0] step_y;
  } request_t;

  // The resolved position and flags that one request produces.
  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic                  hit_x;
    logic                  hit_y;
    logic                  full;
  } resolution_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_ADD;
  logic signed [Q_W-1:0] rect_x   = '0;
  logic signed [Q_W-1:0] rect_y   = '0;
  logic [SZ_W-1:0]       rect_w   = '0;
  logic [SZ_W-1:0]       rect_h   = '0;
  logic signed [Q_W-1:0] pos_x    = '0;
  logic signed [Q_W-1:0] pos_y    = '0;
  logic signed [Q_W-1:0] step_x   = '0;
  logic signed [Q_W-1:0] step_y   = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [Q_W-1:0] new_x;
  logic signed [Q_W-1:0] new_y;
  logic                  blocked_x;
  logic                  blocked_y;
  logic                  table_full;

  aabb_table_move_resolver_core #(
    .MAX_RECTS(MAX_RECTS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .rect_x    (rect_x),
    .rect_y    (rect_y),
    .rect_w    (rect_w),
    .rect_h    (rect_h),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .step_x    (step_x),
    .step_y    (step_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_x     (new_x),
    .new_y     (new_y),
    .blocked_x (blocked_x),
    .blocked_y (blocked_y),
    .table_full(table_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between the stimulus, the driver and the monitor.
  // ---------------------------------------------------------------------------
  request_t    request_q[$];      // requests waiting to be offered
  resolution_t resolved_q[$];     // predicted results, oldest first
  int          sent_total   = 0;  // requests queued so far
  int          done_total   = 0;  // results matched against a prediction
  int          adds_sent    = 0;  // add requests queued so far
  int          error_count  = 0;
  int          gap_max      = 10; // upper bound of the per-request idle draw
  int          hold_requests = 0; // long receiver stalls asked for

  // Our own copy of the block's state: the obstacle table and the hitbox size.
  obst_t           obstacle_mem[MAX_RECTS];
  int              obstacle_total = 0;
  logic [SZ_W-1:0] mover_w        = HITBOX_RST;
  logic [SZ_W-1:0] mover_h        = HITBOX_RST;

  // Prints one line per mismatch (up to a cap) and counts every one of them.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t: mismatch on %0s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor. Every coordinate is widened to 64 bits, so the edge sums
  // (position plus size in pixels times 256) never wrap or saturate.
  // ---------------------------------------------------------------------------
  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // True when a hitbox with its top-left corner at (bx, by) strictly overlaps
  // any stored obstacle. Touching edges do not count.
  function automatic bit box_collides(input longint bx, input longint by);
    longint bw;
    longint bh;
    longint ox;
    longint oy;
    longint ow;
    longint oh;
    bw = longint'({mover_w, 8'h00});
    bh = longint'({mover_h, 8'h00});
    for (int i = 0; i < obstacle_total; i++) begin
      ox = signed'(obstacle_mem[i].x);
      oy = signed'(obstacle_mem[i].y);
      ow = longint'({obstacle_mem[i].w, 8'h00});
      oh = longint'({obstacle_mem[i].h, 8'h00});
      if (bx < ox + ow && bx + bw > ox && by < oy + oh && by + bh > oy)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted request to our state and returns the result it must produce.
  function automatic resolution_t resolve_request(input request_t r);
    resolution_t res;
    longint      px;
    longint      py;
    longint      cx;
    longint      cy;
    res = '0;
    if (r.req_type == REQ_ADD) begin
      // A full table drops the rectangle and raises the flag; nothing else changes.
      if (obstacle_total < MAX_RECTS) begin
        obstacle_mem[obstacle_total] = '{x: r.rect_x, y: r.rect_y, w: r.rect_w, h: r.rect_h};
        obstacle_total++;
      end else begin
        res.full = 1'b1;
      end
    end else begin
      px = signed'(r.pos_x);
      py = signed'(r.pos_y);
      cx = clamp_q(px + signed'(r.step_x));
      cy = clamp_q(py + signed'(r.step_y));
      // X first at the old y, then y at whatever x was resolved. A box that
      // already overlaps is refused even for a zero step.
      if (box_collides(cx, py))
        res.hit_x = 1'b1;
      else
        px = cx;
      if (box_collides(px, cy))
        res.hit_y = 1'b1;
      else
        py = cy;
      res.x = px[Q_W-1:0];
      res.y = py[Q_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. It takes requests from request_q, waits a random number of cycles
  // before each one, and holds valid and the payload until the request is taken.
  // The prediction is made at the edge where the block accepts the request.
  // ---------------------------------------------------------------------------
  request_t offered;
  bit       offering  = 1'b0;
  int       send_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      offering  = 1'b0;
      send_wait = 0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resolved_q.push_back(resolve_request(offered));
        offering  = 1'b0;
        send_wait = $urandom_range(0, gap_max);
      end
      if (!offering) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (request_q.size() != 0) begin
          offered  = request_q.pop_front();
          offering = 1'b1;
          req_type <= offered.req_type;
          rect_x   <= offered.rect_x;
          rect_y   <= offered.rect_y;
          rect_w   <= offered.rect_w;
          rect_h   <= offered.rect_h;
          pos_x    <= offered.pos_x;
          pos_y    <= offered.pos_y;
          step_x   <= offered.step_x;
          step_y   <= offered.step_y;
        end
      end
      // Valid goes out once per edge, so it never drops between back-to-back requests.
      in_valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each accepted result is checked field by field against the oldest
  // prediction. Ready is held low for a random number of cycles of pending
  // results after each one, and for a long stretch when the stimulus asks for it.
  // ---------------------------------------------------------------------------
  resolution_t expected_head;
  int          ready_wait      = 0;
  int          long_hold_left  = 0;
  int          holds_served    = 0;

  always @(posedge clk) begin
    if (rst) begin
      ready_wait     = 0;
      long_hold_left = 0;
      out_ready     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (resolved_q.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          expected_head = resolved_q.pop_front();
          done_total++;
          if (new_x !== expected_head.x)
            report_mismatch("new_x", new_x, signed'(expected_head.x));
          if (new_y !== expected_head.y)
            report_mismatch("new_y", new_y, signed'(expected_head.y));
          if (blocked_x !== expected_head.hit_x)
            report_mismatch("blocked_x", blocked_x, expected_head.hit_x);
          if (blocked_y !== expected_head.hit_y)
            report_mismatch("blocked_y", blocked_y, expected_head.hit_y);
          if (table_full !== expected_head.full)
            report_mismatch("table_full", table_full, expected_head.full);
        end
        ready_wait = $urandom_range(0, gap_max);
      end else if (out_valid && ready_wait > 0) begin
        ready_wait--;
      end
      if (holds_served < hold_requests) begin
        holds_served++;
        long_hold_left = LONG_HOLD;
      end else if (long_hold_left > 0) begin
        long_hold_left--;
      end
      out_ready <= (ready_wait == 0) && (long_hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when nothing moves on any port for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Register write over the configuration port: setup cycle, then access cycle.
  // The upper data bits carry junk, since only the low twelve bits are kept.
  task automatic write_reg(input logic reg_idx, input logic [SZ_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom();
    word[SZ_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_HITBOX_W)
      mover_w = value;
    else
      mover_h = value;
  endtask

  function automatic logic signed [Q_W-1:0] any_q();
    logic [31:0] v;
    v = $urandom();
    return v[Q_W-1:0];
  endfunction

  // A coordinate within +/- span_px pixels, fraction bits included.
  function automatic logic signed [Q_W-1:0] near_q(input int span_px);
    int span;
    int v;
    span = span_px * PX;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[Q_W-1:0];
  endfunction

  task automatic push_request(input request_t r);
    request_q.push_back(r);
    sent_total++;
    if (r.req_type == REQ_ADD)
      adds_sent++;
  endtask

  // Fields a request does not use carry random values, so their bits toggle too.
  function automatic request_t noise_request();
    request_t r;
    r.req_type = 1'($urandom_range(0, 1));
    r.rect_x   = any_q();
    r.rect_y   = any_q();
    r.rect_w   = SZ_W'($urandom_range(0, 4095));
    r.rect_h   = SZ_W'($urandom_range(0, 4095));
    r.pos_x    = any_q();
    r.pos_y    = any_q();
    r.step_x   = any_q();
    r.step_y   = any_q();
    return r;
  endfunction

  task automatic push_add(input longint x, input longint y, input int w, input int h);
    request_t r;
    r = noise_request();
    r.req_type = REQ_ADD;
    r.rect_x   = x[Q_W-1:0];
    r.rect_y   = y[Q_W-1:0];
    r.rect_w   = w[SZ_W-1:0];
    r.rect_h   = h[SZ_W-1:0];
    push_request(r);
  endtask

  task automatic push_move(input longint px, input longint py, input longint sx,
                           input longint sy);
    request_t r;
    r = noise_request();
    r.req_type = REQ_MOVE;
    r.pos_x    = px[Q_W-1:0];
    r.pos_y    = py[Q_W-1:0];
    r.step_x   = sx[Q_W-1:0];
    r.step_y   = sy[Q_W-1:0];
    push_request(r);
  endtask

  // Most random traffic lives in a small world around the origin, so that
  // obstacles are dense and moves really collide. About one request in five
  // adds a rectangle. A share of adds and moves is full-range noise, which
  // also drives the saturation of the stepped position.
  function automatic request_t random_request();
    request_t r;
    int       roll;
    r    = noise_request();
    roll = $urandom_range(0, 99);
    r.req_type = (roll < 20) ? REQ_ADD : REQ_MOVE;
    if (roll < 16) begin
      r.rect_x = near_q(64);
      r.rect_y = near_q(64);
      r.rect_w = SZ_W'($urandom_range(0, 24));
      r.rect_h = SZ_W'($urandom_range(0, 24));
    end else if (roll >= 20 && roll < 88) begin
      r.pos_x  = near_q(80);
      r.pos_y  = near_q(80);
      r.step_x = ($urandom_range(0, 9) == 0) ? '0 : near_q(8);
      r.step_y = ($urandom_range(0, 9) == 0) ? '0 : near_q(8);
    end
    return r;
  endfunction

  // Blocks until every queued request has produced its checked result.
  task automatic wait_idle();
    while (done_total != sent_total) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, then phases. Each phase reprograms the hitbox while
  // the block is idle, then queues its requests and waits for all results.
  // ---------------------------------------------------------------------------
  initial begin
    logic [SZ_W-1:0] cfg_w;
    logic [SZ_W-1:0] cfg_h;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          cfg_w = SZ_W'(16);
          cfg_h = SZ_W'(16);
        end
        1: begin
          cfg_w = '0;
          cfg_h = '0;
        end
        2: begin
          cfg_w = SZ_W'(4095);
          cfg_h = SZ_W'(4095);
        end
        3: begin
          cfg_w = SZ_W'(1);
          cfg_h = SZ_W'(4095);
        end
        4: begin
          cfg_w = SZ_W'($urandom_range(1, 40));
          cfg_h = SZ_W'($urandom_range(1, 40));
        end
        default: begin
          cfg_w = SZ_W'($urandom_range(0, 4095));
          cfg_h = SZ_W'($urandom_range(0, 4095));
        end
      endcase
      write_reg(REG_HITBOX_W, cfg_w);
      write_reg(REG_HITBOX_H, cfg_h);

      // Odd phases run with no idling on either side.
      gap_max = (ph % 2 == 0) ? 10 : 0;

      if (ph == 0) begin
        // Directed part with a 16 x 16 pixel hitbox against a 10 x 10 block at the origin.
        push_add(0, 0, 10, 10);
        // X step into the block is refused; the zero y step at the old x is free.
        push_move(-20 * PX, 0, 5 * PX, 0);
        // Box ends exactly on the block's left edge: touching, so free.
        push_move(-26 * PX, 0, 10 * PX, 0);
        // Already overlapping: zero steps are still reported as blocked.
        push_move(2 * PX, 2 * PX, 0, 0);
        // Y step into the block from above is refused, then a touching one is free.
        push_move(0, -30 * PX, 0, 20 * PX);
        push_move(0, -30 * PX, 0, 14 * PX);
        // Touching by one fraction step, then overlapping by one.
        push_move(-16 * PX - 1, 0, 1, 0);
        push_move(-16 * PX - 1, 0, 2, 0);
        // Rectangles at the corners of the coordinate range with the largest sizes,
        // where the edge sums run past the 24-bit range.
        push_add(Q_HI, Q_HI, 4095, 4095);
        push_add(Q_LO, Q_LO, 4095, 4095);
        push_add(Q_LO, 0, 0, 4095);
        // Stepped positions saturate at both ends and land in those rectangles.
        push_move(Q_HI, Q_HI, Q_HI, Q_HI);
        push_move(Q_LO, Q_LO, Q_LO, Q_LO);
        // Saturated x is free at a small y; saturated y then hits the low corner.
        push_move(0, 100 * PX, Q_HI, 0);
        push_move(-100 * PX, -100 * PX, Q_LO, Q_LO);
        // A zero-size rectangle still blocks a box that spans it.
        push_add(50 * PX, 50 * PX, 0, 0);
        push_move(40 * PX, 45 * PX, 2 * PX, 0);
        push_move(40 * PX, 45 * PX, -2 * PX, 0);
        // Largest steps from the far corners, both directions.
        push_move(Q_LO, Q_HI, Q_HI, Q_LO);
        push_move(Q_HI, Q_LO, Q_LO, Q_HI);
      end

      // Make sure the table overflows: top it up with adds if random traffic has not.
      if (ph == 4) begin
        while (adds_sent < MAX_RECTS + 4) begin
          request_t r;
          r = random_request();
          r.req_type = REQ_ADD;
          push_request(r);
        end
      end

      // A long receiver stall while the queue is full of requests: the block
      // fills up and has to hold off its input.
      if (ph == 2)
        hold_requests++;

      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // Halfway through one phase the sender stops until everything is back.
        if (ph == 3 && k == RANDOM_PER_PHASE / 2)
          wait_idle();
        push_request(random_request());
      end

      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    if (resolved_q.size() != 0)
      report_mismatch("results never delivered", done_total, sent_total);

    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/atmr_pkg.sv
sv/atmr_ctrl.sv
sv/atmr_dp.sv
sv/aabb_table_move_resolver_core.sv
tb/sv/tb.sv
